FILE: design/lrm_pkg.sv
// Shared types, constants and table-building functions for the logistic ramp mapper.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package lrm_pkg;

	localparam int LRM_DATA_W      = 16;
	localparam int LRM_CURVE_DEPTH = 1024;
	localparam int LRM_QUOT_W      = 17;
	localparam int LRM_DIVD_W      = 33;
	localparam int LRM_ARG_SPAN    = 40960;
	localparam int LRM_HALF_Q16    = 32768;

	localparam longint LRM_Q30_ONE = longint'(1) <<< 30;
	localparam longint LRM_LN2_Q30 = longint'(744261118);

	typedef enum logic [2:0] {
		CFG_IN_LO    = 3'd0,
		CFG_IN_HI    = 3'd1,
		CFG_OUT_LO   = 3'd2,
		CFG_OUT_HI   = 3'd3,
		CFG_INV_MODE = 3'd4
	} lrm_cfg_idx_t;

	typedef struct packed {
		logic vld;
		logic degen;
		logic clip;
	} lrm_ctl_t;

	// {logit clip, logit argument + 10 in Q4.12, logistic value in Q0.16}
	typedef logic [32:0] lrm_rom_word_t;

	// Truncating shift-and-subtract division of non-negative n by positive d.
	// Used only while building tables.
	function automatic longint lrm_udiv(longint n, longint d);
		longint q;
		longint rem;
		q = 0;
		rem = 0;
		for (int b = 62; b >= 0; b--) begin
			rem = (rem <<< 1) | ((n >>> b) & longint'(1));
			if (rem >= d) begin
				rem = rem - d;
				q = q | (longint'(1) <<< b);
			end
		end
		return q;
	endfunction

	// Rounded division, ties away from zero. Used only while building tables.
	function automatic longint lrm_rdiv(longint n, longint d);
		longint nn;
		longint dd;
		nn = n;
		dd = d;
		if (dd < 0) begin
			nn = -nn;
			dd = -dd;
		end
		if (nn >= 0)
			return lrm_udiv(nn + (dd >>> 1), dd);
		return -lrm_udiv(-nn + (dd >>> 1), dd);
	endfunction

	// Logistic curve value for grid point idx of a table of depth entries.
	function automatic logic [15:0] lrm_logistic_entry(int idx, int depth);
		longint d1;
		longint t;
		longint big;
		longint k;
		longint r;
		longint sum;
		longint term;
		longint e_big;
		longint y;
		d1 = longint'(depth - 1);
		t = longint'(LRM_ARG_SPAN) - lrm_rdiv(longint'(idx) * LRM_ARG_SPAN, d1);
		big = t <<< 18;
		k = lrm_udiv(big, LRM_LN2_Q30);
		r = big - k * LRM_LN2_Q30;
		sum = LRM_Q30_ONE;
		term = LRM_Q30_ONE;
		for (int n = 1; n <= 13; n++) begin
			term = lrm_udiv((term * r) >>> 30, longint'(n));
			if (n[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		e_big = (k >= 62) ? longint'(0) : (sum >>> k);
		y = lrm_udiv((e_big <<< 16) + ((LRM_Q30_ONE + e_big) >>> 1),
			LRM_Q30_ONE + e_big);
		return y[15:0];
	endfunction

	// Natural logarithm of an integer v >= 1 in Q30.
	function automatic longint lrm_ln_q30(longint v);
		longint k;
		longint m;
		longint z;
		longint z2;
		longint p;
		longint sum;
		k = 0;
		sum = 0;
		for (int b = 0; b < 40; b++) begin
			if ((v >>> (k + 1)) != 0)
				k = k + 1;
		end
		m = (v <<< 30) >>> k;
		z = lrm_udiv((m - LRM_Q30_ONE) <<< 30, m + LRM_Q30_ONE);
		z2 = (z * z) >>> 30;
		p = z;
		for (int n = 1; n <= 29; n += 2) begin
			sum = sum + lrm_udiv(p, longint'(n));
			p = (p * z2) >>> 30;
		end
		return k * LRM_LN2_Q30 + 2 * sum;
	endfunction

	// Logit for grid point idx: {clip, argument offset by the span, 16 bits}.
	function automatic logic [16:0] lrm_logit_entry(int idx, int depth);
		longint d1;
		longint g;
		longint a;
		longint w;
		logic   clip;
		d1 = longint'(depth - 1);
		g = lrm_rdiv(longint'(idx) * LRM_HALF_Q16, d1);
		clip = 1'b0;
		if (g <= 0) begin
			a = -longint'(LRM_ARG_SPAN);
			clip = 1'b1;
		end else begin
			a = lrm_rdiv(lrm_ln_q30(g) - lrm_ln_q30(longint'(65536) - g),
				longint'(1) <<< 18);
			if (a < -longint'(LRM_ARG_SPAN)) begin
				a = -longint'(LRM_ARG_SPAN);
				clip = 1'b1;
			end
			if (a > 0) begin
				a = 0;
				clip = 1'b1;
			end
		end
		w = a + LRM_ARG_SPAN;
		return {clip, w[15:0]};
	endfunction

endpackage

FILE: design/lrm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detection.
// Depends on lrm_pkg for widths and the control struct.
`timescale 1ns / 1ps

module lrm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lrm_pkg::lrm_ctl_t                 ctl_in,
	input  logic [lrm_pkg::LRM_DIVD_W-1:0]    dividend,
	input  logic [15:0]                       divisor,
	input  logic                              neg_in,
	output lrm_pkg::lrm_ctl_t                 ctl_out,
	output logic [lrm_pkg::LRM_QUOT_W-1:0]    quot,
	output logic                              ovf,
	output logic                              neg_out
);
	import lrm_pkg::*;

	localparam int QW = LRM_QUOT_W;

	lrm_ctl_t        ctl_s [QW+1];
	logic [15:0]     rem_s [QW+1];
	logic [QW-1:0]   low_s [QW+1];
	logic [QW-1:0]   quo_s [QW+1];
	logic            ovf_s [QW+1];
	logic            neg_s [QW+1];

	logic [16:0]     trial [QW];
	logic [16:0]     diff  [QW];
	logic            ge    [QW];

	always_comb begin
		for (int g = 0; g < QW; g++) begin
			trial[g] = {rem_s[g], low_s[g][QW-1]};
			diff[g]  = trial[g] - {1'b0, divisor};
			ge[g]    = trial[g] >= {1'b0, divisor};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= QW; g++)
				ctl_s[g] <= '0;
		end else begin
			ctl_s[0] <= ctl_in;
			for (int g = 0; g < QW; g++)
				ctl_s[g+1] <= ctl_s[g];
		end
	end

	always_ff @(posedge clk) begin
		// Quotients of 2^17 or more only ever saturate, so they are flagged instead.
		ovf_s[0] <= dividend >= {divisor, {QW{1'b0}}};
		rem_s[0] <= dividend[LRM_DIVD_W-1:QW];
		low_s[0] <= dividend[QW-1:0];
		quo_s[0] <= '0;
		neg_s[0] <= neg_in;
		for (int g = 0; g < QW; g++) begin
			rem_s[g+1] <= ge[g] ? diff[g][15:0] : trial[g][15:0];
			low_s[g+1] <= {low_s[g][QW-2:0], 1'b0};
			quo_s[g+1] <= {quo_s[g][QW-2:0], ge[g]};
			ovf_s[g+1] <= ovf_s[g];
			neg_s[g+1] <= neg_s[g];
		end
	end

	assign ctl_out = ctl_s[QW];
	assign quot    = quo_s[QW];
	assign ovf     = ovf_s[QW];
	assign neg_out = neg_s[QW];

endmodule

FILE: design/lrm_rom.sv
// Curve table holding the logistic and logit values for every grid point.
// Depends on lrm_pkg for the word type and the table-building functions.
`timescale 1ns / 1ps

module lrm_rom #(
	parameter int CurveDepth = lrm_pkg::LRM_CURVE_DEPTH,
	localparam int IdxW = $clog2(CurveDepth)
) (
	input  logic                      clk,
	input  logic [IdxW-1:0]           idx,
	output lrm_pkg::lrm_rom_word_t    word
);
	import lrm_pkg::*;

	typedef lrm_rom_word_t rom_arr_t [CurveDepth];

	function automatic rom_arr_t build_rom();
		rom_arr_t arr;
		for (int i = 0; i < CurveDepth; i++)
			arr[i] = {lrm_logit_entry(i, CurveDepth), lrm_logistic_entry(i, CurveDepth)};
		return arr;
	endfunction

	localparam rom_arr_t RomInit = build_rom();

	lrm_rom_word_t word_q;

	always_ff @(posedge clk) begin
		word_q <= RomInit[idx];
	end

	assign word = word_q;

endmodule

FILE: design/lrm_post.sv
// Output scaling: curve value times the result span, rounding, offset and saturation.
// Depends on lrm_pkg for the control struct and the table word layout.
`timescale 1ns / 1ps

module lrm_post (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lrm_pkg::lrm_ctl_t           ctl_in,
	input  lrm_pkg::lrm_rom_word_t      word,
	input  logic                        inv_mode,
	input  logic signed [15:0]          out_lo,
	input  logic signed [15:0]          out_hi,
	output logic                        done,
	output logic signed [15:0]          mapped,
	output logic                        clipped
);
	import lrm_pkg::*;

	localparam logic [41:0] RecipFive = 42'd3355444;

	logic signed [16:0] span;
	logic [16:0]        span_n;
	logic [15:0]        span_mag;
	logic [15:0]        val;
	logic [32:0]        rnd;
	logic [41:0]        rprod;
	logic signed [18:0] offs;
	logic signed [18:0] sres;

	lrm_ctl_t           ctl_s1, ctl_s2, ctl_s3;
	logic [31:0]        mag_s1;
	logic               neg_s1, neg_s2, neg_s3;
	logic [19:0]        v_s2;
	logic [17:0]        mag_s3;

	logic               done_q;
	logic signed [15:0] mapped_q;
	logic               clipped_q;

	assign span     = {out_hi[15], out_hi} - {out_lo[15], out_lo};
	assign span_n   = -span;
	assign span_mag = span[16] ? span_n[15:0] : span[15:0];
	assign val      = inv_mode ? word[31:16] : word[15:0];
	assign rnd      = {1'b0, mag_s1} + (inv_mode ? 33'd20480 : 33'd16384);
	assign rprod    = 42'(v_s2) * RecipFive;
	assign offs     = neg_s3 ? -$signed({1'b0, mag_s3}) : $signed({1'b0, mag_s3});
	assign sres     = {{3{out_lo[15]}}, out_lo} + offs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= '{vld: ctl_in.vld, degen: ctl_in.degen,
				clip: ctl_in.clip | (inv_mode & word[32])};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			done_q <= ctl_s3.vld;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= 32'(val) * 32'(span_mag);
		neg_s1 <= span[16];
		// Forward divides by 2^15; inverse divides by 2^13 here and by five next.
		v_s2   <= inv_mode ? rnd[32:13] : 20'(rnd[32:15]);
		neg_s2 <= neg_s1;
		mag_s3 <= inv_mode ? rprod[24 +: 18] : v_s2[17:0];
		neg_s3 <= neg_s2;
		if (ctl_s3.degen) begin
			mapped_q  <= out_lo;
			clipped_q <= 1'b1;
		end else if (sres > 19'sd32767) begin
			mapped_q  <= 16'sh7fff;
			clipped_q <= 1'b1;
		end else if (sres < -19'sd32768) begin
			mapped_q  <= -16'sh8000;
			clipped_q <= 1'b1;
		end else begin
			mapped_q  <= sres[15:0];
			clipped_q <= ctl_s3.clip;
		end
	end

	assign done    = done_q;
	assign mapped  = mapped_q;
	assign clipped = clipped_q;

endmodule

FILE: design/logistic_ramp_mapper_top.sv
// Top level of the logistic ramp mapper: configuration, input scaling and table indexing.
// Depends on lrm_pkg, lrm_div, lrm_rom and lrm_post.
`timescale 1ns / 1ps

// Channel    Ports                                   Transaction
// ---------  --------------------------------------  -----------------------------------
// input      start, busy, sample                     start high and busy low at a clk edge
// result     done, mapped, clipped                   done high for one cycle, always taken
// config     cfg_we, cfg_idx, cfg_wdata              cfg_we high at a clk edge
//
// One sample is taken every clock cycle while busy is low. The pipeline is made up of
// the divider, which has an input register and resolves one quotient bit per stage
// over seventeen further stages, plus the table read and output scaling.
// Busy is high in reset and for the first cycle after reset is released. The receiver
// cannot hold results off, so nothing in the pipeline ever stalls.
// Configuration must be written only while no transaction is in flight.

module logistic_ramp_mapper_top #(
	parameter int CurveDepth = lrm_pkg::LRM_CURVE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  sample,
	output logic                done,
	output logic signed [15:0]  mapped,
	output logic                clipped,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [15:0]         cfg_wdata
);
	import lrm_pkg::*;

	localparam int IdxW = $clog2(CurveDepth);
	// Width of w * (depth - 1) plus the rounding bias.
	localparam int PW   = $clog2(LRM_ARG_SPAN * (CurveDepth - 1) + LRM_ARG_SPAN / 2 + 1);
	localparam int VW   = PW - 13;
	localparam logic [PW-1:0] FwdBias = PW'(LRM_ARG_SPAN / 2);
	localparam logic [PW-1:0] InvBias = PW'(LRM_HALF_Q16 / 2);
	localparam logic [VW+15:0] RecipFive = (VW + 16)'(52429);
	localparam logic [16:0] FwdLimit = 17'(LRM_ARG_SPAN);
	localparam logic [16:0] InvLimit = 17'(LRM_HALF_Q16);

	// Configuration registers
	logic signed [15:0] in_lo_q, in_hi_q, out_lo_q, out_hi_q;
	logic               inv_mode_q;
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_lo_q    <= 16'sd0;
			in_hi_q    <= 16'sd32767;
			out_lo_q   <= 16'sd0;
			out_hi_q   <= 16'sd32767;
			inv_mode_q <= 1'b0;
			busy_q     <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_IN_LO:    in_lo_q    <= cfg_wdata;
					CFG_IN_HI:    in_hi_q    <= cfg_wdata;
					CFG_OUT_LO:   out_lo_q   <= cfg_wdata;
					CFG_OUT_HI:   out_hi_q   <= cfg_wdata;
					CFG_INV_MODE: inv_mode_q <= cfg_wdata[0];
					default:      ;
				endcase
			end
		end
	end

	assign busy = busy_q;

	// Stage 1: offset from the range base and the scaled numerator. The forward
	// argument span of 40960 is five times 2^13; the inverse span is 2^15.
	logic signed [16:0]         num, dn;
	logic [16:0]                num_n, dn_n;
	logic [15:0]                num_mag, dn_mag;
	logic [18:0]                num_x5;
	logic [31:0]                n_mag;
	logic [LRM_DIVD_W-1:0]      dividend;

	assign num     = {sample[15], sample} - {in_lo_q[15], in_lo_q};
	assign dn      = {in_hi_q[15], in_hi_q} - {in_lo_q[15], in_lo_q};
	assign num_n   = -num;
	assign dn_n    = -dn;
	assign num_mag = num[16] ? num_n[15:0] : num[15:0];
	assign dn_mag  = dn[16] ? dn_n[15:0] : dn[15:0];
	assign num_x5  = {1'b0, num_mag, 2'b00} + {3'b000, num_mag};
	assign n_mag   = inv_mode_q ? {1'b0, num_mag, 15'd0} : {num_x5, 13'd0};
	// Adding half the divisor makes the truncating divider round to nearest.
	assign dividend = {1'b0, n_mag} + {18'd0, dn_mag[15:1]};

	lrm_ctl_t                ctl_s1;
	logic [LRM_DIVD_W-1:0]   dividend_s1;
	logic                    neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s1 <= '0;
		else
			ctl_s1 <= '{vld: start & ~busy_q, degen: (dn == 17'sd0), clip: 1'b0};
	end

	always_ff @(posedge clk) begin
		dividend_s1 <= dividend;
		neg_s1      <= num[16] ^ dn[16];
	end

	// Divider pipeline: quotient magnitude, overflow and sign.
	lrm_ctl_t                 div_ctl;
	logic [LRM_QUOT_W-1:0]    div_quot;
	logic                     div_ovf;
	logic                     div_neg;

	lrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_s1),
		.dividend (dividend_s1),
		.divisor  (dn_mag),
		.neg_in   (neg_s1),
		.ctl_out  (div_ctl),
		.quot     (div_quot),
		.ovf      (div_ovf),
		.neg_out  (div_neg)
	);

	// Stage 2: clamp the argument onto its domain, then scale it onto the grid.
	logic [16:0]      limit;
	logic [15:0]      w;
	logic             w_clip;
	logic [PW-1:0]    p_grid;

	assign limit = inv_mode_q ? InvLimit : FwdLimit;

	always_comb begin
		if (div_neg && (div_ovf || (div_quot != '0))) begin
			w      = 16'd0;
			w_clip = 1'b1;
		end else if (div_ovf || (div_quot > limit)) begin
			w      = limit[15:0];
			w_clip = 1'b1;
		end else begin
			w      = div_quot[15:0];
			w_clip = 1'b0;
		end
	end

	assign p_grid = PW'(32'(w) * 32'(CurveDepth - 1)) + (inv_mode_q ? InvBias : FwdBias);

	lrm_ctl_t         ctl_s2;
	logic [PW-1:0]    p_grid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s2 <= '0;
		else
			ctl_s2 <= '{vld: div_ctl.vld, degen: div_ctl.degen, clip: div_ctl.clip | w_clip};
	end

	always_ff @(posedge clk) begin
		p_grid_s2 <= p_grid;
	end

	// Stage 3: table index. Forward divides by 40960 as a shift by 13 and a
	// multiply by the reciprocal of five; inverse divides by 2^15.
	logic [VW+15:0]   v_prod;
	logic [IdxW-1:0]  idx_fwd;

	assign v_prod  = (VW + 16)'(p_grid_s2[PW-1:13]) * RecipFive;
	assign idx_fwd = v_prod[18 +: IdxW];

	lrm_ctl_t         ctl_s3;
	logic [IdxW-1:0]  idx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s3 <= '0;
		else
			ctl_s3 <= ctl_s2;
	end

	always_ff @(posedge clk) begin
		idx_s3 <= inv_mode_q ? p_grid_s2[15 +: IdxW] : idx_fwd;
	end

	// Stage 4: curve table read.
	lrm_rom_word_t    rom_word;
	lrm_ctl_t         ctl_s4;

	lrm_rom #(
		.CurveDepth (CurveDepth)
	) u_rom (
		.clk  (clk),
		.idx  (idx_s3),
		.word (rom_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s4 <= '0;
		else
			ctl_s4 <= ctl_s3;
	end

	// Stages 5 to 8: scaling onto the result range and saturation.
	lrm_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_s4),
		.word     (rom_word),
		.inv_mode (inv_mode_q),
		.out_lo   (out_lo_q),
		.out_hi   (out_hi_q),
		.done     (done),
		.mapped   (mapped),
		.clipped  (clipped)
	);

endmodule
